FILE: design/ogru_pkg.sv
// Shared widths, codes and constants of the occupancy grid ray update block.
package ogru_pkg;

  localparam int OGRU_GRID_WIDTH  = 256;
  localparam int OGRU_GRID_HEIGHT = 256;

  // Field widths.
  localparam int POS_W       = 21;
  localparam int ANG_W       = 16;
  localparam int RANGE_W     = 16;
  localparam int BEAM_W      = 12;
  localparam int SEL_W       = 8;
  localparam int CELL_SIZE_W = 10;
  localparam int CMD_W       = 2;
  localparam int STATUS_W    = 3;
  localparam int VALUE_W     = 2;
  localparam int FREED_W     = 9;

  // Stream payload layout.
  localparam int IN_DATA_W   = 104;
  localparam int OUT_DATA_W  = 16;
  localparam int IN_RX_LO    = 0;
  localparam int IN_RY_LO    = 21;
  localparam int IN_HEAD_LO  = 42;
  localparam int IN_RANGE_LO = 58;
  localparam int IN_BEAM_LO  = 74;
  localparam int IN_CX_LO    = 86;
  localparam int IN_CY_LO    = 94;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 21;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ANG = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ANG_STEP  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RANGE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RANGE = 3'd6;

  // Commands.
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CAST  = 2'd1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_HIT       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MAX_RANGE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_SHORT     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_END_OUT   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ROBOT_OUT = 3'd4;
  localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd5;
  localparam logic [STATUS_W-1:0] ST_CELL_READ = 3'd6;

  // Cell codes.
  localparam logic [VALUE_W-1:0] CELL_UNKNOWN  = 2'd0;
  localparam logic [VALUE_W-1:0] CELL_FREE     = 2'd1;
  localparam logic [VALUE_W-1:0] CELL_OCCUPIED = 2'd2;

  // Sine polynomial, Q14 angle within a quarter turn.
  localparam int SIN_C0   = 10512;
  localparam int SIN_C1   = 1160;
  localparam int SIN_C2   = 25736;
  localparam int QUARTER  = 16384;
  localparam int SIN_MAX  = 32767;

  // Cell conversion arithmetic.
  localparam int END_W  = 23;
  localparam int DIFF_W = 25;
  localparam int QUO_W  = 24;

endpackage

FILE: design/ogru_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module ogru_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/occupancy_grid_ray_update.sv
// Occupancy grid kept in RAM, updated by Bresenham beam casting.
//
//  Channel   Direction  Handshake                      Payload
//  s_axis    in         s_axis_tvalid / s_axis_tready  tuser: cmd; tdata: beam and cell select
//  m_axis    out        m_axis_tvalid / m_axis_tready  tuser: status; tdata: value, freed count
//  cfg       in         cfg_write (no wait)            cfg_index, cfg_data
//
// A request is taken only while the sequencer is idle; a finished result sits in the output
// register, so the next request can be taken while that result still waits.
// A read presents its address to the grid RAM while idle and takes the registered data in
// the read state. A clear sweeps the grid one cell per cycle. A cast runs the four cell
// conversions (a one-bit-per-cycle divider), the angle and sine/cosine steps, and for each
// cell on the line short of the end cell a read, then a modify and write back through the single grid RAM.
// After reset the same sweep clears the grid and no request is taken until it ends;
// configuration writes are taken at any time.
module occupancy_grid_ray_update
  import ogru_pkg::*;
#(
  parameter int GRID_WIDTH  = OGRU_GRID_WIDTH,
  parameter int GRID_HEIGHT = OGRU_GRID_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata: robot_x_mm, robot_y_mm, heading, range_mm, beam_index, cell_x, cell_y, zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: cmd
  input  logic [CMD_W-1:0]      s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata: cell_value, cells_freed, zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // tuser: status
  output logic [STATUS_W-1:0]   m_axis_tuser,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int CXW   = $clog2(GRID_WIDTH);
  localparam int CYW   = $clog2(GRID_HEIGHT);
  localparam int CW    = (CXW > CYW) ? CXW : CYW;
  localparam int ES    = CW + 2;
  localparam int CNT_W = $clog2(QUO_W);

  typedef enum logic [18:0] {
    S_INIT       = 19'h00001,
    S_IDLE       = 19'h00002,
    S_CLEAR      = 19'h00004,
    S_READ       = 19'h00008,
    S_CONV_START = 19'h00010,
    S_CONV_RUN   = 19'h00020,
    S_CONV_END   = 19'h00040,
    S_ANGLE      = 19'h00080,
    S_TRIG_Z     = 19'h00100,
    S_TRIG_Z2    = 19'h00200,
    S_TRIG_T1    = 19'h00400,
    S_TRIG_T2    = 19'h00800,
    S_TRIG_S     = 19'h01000,
    S_TRIG_P     = 19'h02000,
    S_LINE_SETUP = 19'h04000,
    S_LINE_CHECK = 19'h08000,
    S_LINE_RMW   = 19'h10000,
    S_MARK       = 19'h20000,
    S_DONE       = 19'h40000
  } state_t;

  state_t state;

  // Configuration registers.
  logic signed [POS_W-1:0]   origin_x, origin_y;
  logic [CELL_SIZE_W-1:0]    cell_size;
  logic [ANG_W-1:0]          first_ang, beam_incr;
  logic [RANGE_W-1:0]        min_range, max_range;

  // Request fields.
  logic signed [POS_W-1:0] in_rx, in_ry;
  logic [ANG_W-1:0]        in_heading;
  logic [RANGE_W-1:0]      in_range;
  logic [BEAM_W-1:0]       in_beam;
  logic [SEL_W-1:0]        in_cx, in_cy;
  logic [CW+SEL_W-1:0]     sel_x_ext, sel_y_ext;
  logic                    sel_in_grid;

  assign in_rx      = s_axis_tdata[IN_RX_LO +: POS_W];
  assign in_ry      = s_axis_tdata[IN_RY_LO +: POS_W];
  assign in_heading = s_axis_tdata[IN_HEAD_LO +: ANG_W];
  assign in_range   = s_axis_tdata[IN_RANGE_LO +: RANGE_W];
  assign in_beam    = s_axis_tdata[IN_BEAM_LO +: BEAM_W];
  assign in_cx      = s_axis_tdata[IN_CX_LO +: SEL_W];
  assign in_cy      = s_axis_tdata[IN_CY_LO +: SEL_W];
  assign sel_x_ext  = (CW+SEL_W)'(in_cx);
  assign sel_y_ext  = (CW+SEL_W)'(in_cy);
  assign sel_in_grid = (32'(in_cx) < GRID_WIDTH) && (32'(in_cy) < GRID_HEIGHT);

  // Working registers of one beam.
  logic signed [POS_W-1:0] rx, ry;
  logic [RANGE_W-1:0]      req_range, rng;
  logic [ANG_W-1:0]        req_heading, ang;
  logic [BEAM_W-1:0]       req_beam;
  logic                    clamped;
  logic signed [END_W-1:0] ex, ey;
  logic [1:0]              target;
  logic [CW-1:0]           x0, y0, x1, y1;

  // Divider.
  logic [QUO_W-1:0]       div_q;
  logic [CELL_SIZE_W-1:0] div_r, div_cs;
  logic [CNT_W-1:0]       div_cnt;
  logic [CELL_SIZE_W:0]   div_shift;
  logic                   div_bit;
  logic signed [END_W-1:0]  conv_w;
  logic signed [POS_W-1:0]  conv_o;
  logic signed [DIFF_W-1:0] conv_diff;
  logic                     conv_fits;

  // Sine unit.
  logic                 trig_phase;
  logic [1:0]           quad;
  logic [14:0]          z, z2, t;
  logic signed [15:0]   s;
  logic [29:0]          mul_zz, mul_tz2, mul_zt;
  logic [25:0]          mul_c1;
  logic [ANG_W-1:0]     trig_ang;
  logic [16:0]          s_raw;
  logic [14:0]          s_mag;
  logic signed [32:0]   prod;
  logic signed [17:0]   prod_sh;
  logic signed [END_W-1:0] end_val;

  // Line tracing.
  logic [CW-1:0]          cx, cy;
  logic [CW-1:0]          dx, dy;
  logic                   sx, sy;
  logic signed [ES-1:0]   err;
  logic signed [ES:0]     e2;
  logic                   step_x, step_y;

  // Results.
  logic [STATUS_W-1:0] res_status;
  logic [VALUE_W-1:0]  res_value;
  logic [FREED_W-1:0]  freed;
  logic                rd_oob;
  logic [AW-1:0]       clr_addr;

  // Grid RAM port signals.
  logic                ram_we;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [VALUE_W-1:0]  ram_wdata, ram_rdata;

  // Output register.
  logic [STATUS_W-1:0] out_status;
  logic [VALUE_W-1:0]  out_value;
  logic [FREED_W-1:0]  out_freed;
  logic                out_load;

  function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] x, input logic [CW-1:0] y);
    return AW'(AW'(y) * AW'(GRID_WIDTH)) + AW'(x);
  endfunction

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tdata  = {(OUT_DATA_W-VALUE_W-FREED_W)'(0), out_freed, out_value};
  assign m_axis_tuser  = out_status;

  // The finished result moves into the output register once that register is free or
  // is being emptied in the same cycle.
  assign out_load = (state == S_DONE) && (!m_axis_tvalid || m_axis_tready);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x  <= '0;
      origin_y  <= '0;
      cell_size <= CELL_SIZE_W'(50);
      first_ang <= '0;
      beam_incr <= '0;
      min_range <= '0;
      max_range <= '1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_ORIGIN_X:  origin_x  <= cfg_data[POS_W-1:0];
        CFG_ORIGIN_Y:  origin_y  <= cfg_data[POS_W-1:0];
        CFG_CELL_SIZE: cell_size <= cfg_data[CELL_SIZE_W-1:0];
        CFG_FIRST_ANG: first_ang <= cfg_data[ANG_W-1:0];
        CFG_ANG_STEP:  beam_incr <= cfg_data[ANG_W-1:0];
        CFG_MIN_RANGE: min_range <= cfg_data[RANGE_W-1:0];
        CFG_MAX_RANGE: max_range <= cfg_data[RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  // Point to convert: robot x, robot y, end x, end y, in that order.
  always_comb begin
    case (target)
      2'd0:    begin conv_w = END_W'(rx); conv_o = origin_x; end
      2'd1:    begin conv_w = END_W'(ry); conv_o = origin_y; end
      2'd2:    begin conv_w = ex;         conv_o = origin_x; end
      default: begin conv_w = ey;         conv_o = origin_y; end
    endcase
    conv_diff = DIFF_W'(conv_w) - DIFF_W'(conv_o);
    conv_fits = target[0] ? (div_q < QUO_W'(GRID_HEIGHT)) : (div_q < QUO_W'(GRID_WIDTH));
  end

  // One restoring division step.
  assign div_shift = {div_r, div_q[QUO_W-1]};
  assign div_bit   = (div_shift >= {1'b0, div_cs});

  // Sine datapath, at most one multiplication per state.
  assign trig_ang = trig_phase ? ang : ang + ANG_W'(QUARTER);
  assign mul_zz   = 30'(z) * 30'(z);
  assign mul_c1   = 26'(SIN_C1) * 26'(z2);
  assign mul_tz2  = 30'(t) * 30'(z2);
  assign mul_zt   = 30'(z) * 30'(t);
  assign s_raw    = mul_zt[29:13];
  assign s_mag    = (s_raw > 17'(SIN_MAX)) ? 15'(SIN_MAX) : s_raw[14:0];
  assign prod     = $signed({1'b0, rng}) * s;
  assign prod_sh  = prod[32:15];
  assign end_val  = (trig_phase ? END_W'(ry) : END_W'(rx)) + END_W'(prod_sh);

  // Bresenham decisions.
  assign e2     = {err, 1'b0};
  assign step_x = e2 > -$signed((ES+1)'(dy));
  assign step_y = e2 < $signed((ES+1)'(dx));

  // Grid RAM access.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cell_addr(cx, cy);
    ram_wdata = CELL_FREE;
    ram_raddr = cell_addr(cx, cy);
    if (state == S_IDLE) begin
      ram_raddr = cell_addr(sel_x_ext[CW-1:0], sel_y_ext[CW-1:0]);
    end
    if (state == S_INIT || state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = CELL_UNKNOWN;
    end else if (state == S_LINE_RMW) begin
      ram_we = (ram_rdata == CELL_UNKNOWN);
    end else if (state == S_MARK) begin
      ram_we    = !clamped;
      ram_waddr = cell_addr(x1, y1);
      ram_wdata = CELL_OCCUPIED;
    end
  end

  ogru_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(DEPTH)
  ) u_grid (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_INIT;
      clr_addr      <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH-1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          res_value <= CELL_UNKNOWN;
          freed     <= '0;
          clr_addr  <= '0;
          rx          <= in_rx;
          ry          <= in_ry;
          req_heading <= in_heading;
          req_range   <= in_range;
          req_beam    <= in_beam;
          rd_oob      <= !sel_in_grid;
          target      <= 2'd0;
          clamped     <= 1'b0;
          if (s_axis_tvalid) begin
            if (s_axis_tuser == CMD_CLEAR) begin
              state <= S_CLEAR;
            end else if (s_axis_tuser == CMD_CAST) begin
              state <= S_CONV_START;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH-1)) begin
            res_status <= ST_CLEARED;
            state      <= S_DONE;
          end
        end
        S_READ: begin
          res_value  <= rd_oob ? CELL_UNKNOWN : ram_rdata;
          res_status <= ST_CELL_READ;
          state      <= S_DONE;
        end
        S_CONV_START: begin
          div_q   <= conv_diff[QUO_W-1:0];
          div_r   <= '0;
          div_cnt <= '0;
          div_cs  <= (cell_size == '0) ? CELL_SIZE_W'(1) : cell_size;
          if (conv_diff < 0) begin
            res_status <= target[1] ? ST_END_OUT : ST_ROBOT_OUT;
            state      <= S_DONE;
          end else begin
            state <= S_CONV_RUN;
          end
        end
        S_CONV_RUN: begin
          div_r   <= div_bit ? CELL_SIZE_W'(div_shift - {1'b0, div_cs}) : div_shift[CELL_SIZE_W-1:0];
          div_q   <= {div_q[QUO_W-2:0], div_bit};
          div_cnt <= div_cnt + CNT_W'(1);
          if (div_cnt == CNT_W'(QUO_W-1)) begin
            state <= S_CONV_END;
          end
        end
        S_CONV_END: begin
          if (!conv_fits) begin
            res_status <= target[1] ? ST_END_OUT : ST_ROBOT_OUT;
            state      <= S_DONE;
          end else begin
            unique case (target)
              2'd0: begin
                x0     <= div_q[CW-1:0];
                target <= 2'd1;
                state  <= S_CONV_START;
              end
              2'd1: begin
                y0 <= div_q[CW-1:0];
                // A range above the maximum is clamped and skips the short-range check.
                if (req_range > max_range) begin
                  rng     <= max_range;
                  clamped <= 1'b1;
                  state   <= S_ANGLE;
                end else if (req_range < min_range) begin
                  res_status <= ST_SHORT;
                  state      <= S_DONE;
                end else begin
                  rng   <= req_range;
                  state <= S_ANGLE;
                end
              end
              2'd2: begin
                x1     <= div_q[CW-1:0];
                target <= 2'd3;
                state  <= S_CONV_START;
              end
              default: begin
                y1    <= div_q[CW-1:0];
                state <= S_LINE_SETUP;
              end
            endcase
          end
        end
        S_ANGLE: begin
          ang        <= req_heading + first_ang + ANG_W'(req_beam * beam_incr);
          trig_phase <= 1'b0;
          state      <= S_TRIG_Z;
        end
        S_TRIG_Z: begin
          quad  <= trig_ang[15:14];
          z     <= trig_ang[14] ? 15'(15'(QUARTER) - {1'b0, trig_ang[13:0]})
                                : {1'b0, trig_ang[13:0]};
          state <= S_TRIG_Z2;
        end
        S_TRIG_Z2: begin
          z2    <= mul_zz[28:14];
          state <= S_TRIG_T1;
        end
        S_TRIG_T1: begin
          t     <= 15'(SIN_C0) - 15'(mul_c1[25:14]);
          state <= S_TRIG_T2;
        end
        S_TRIG_T2: begin
          t     <= 15'(SIN_C2) - mul_tz2[28:14];
          state <= S_TRIG_S;
        end
        S_TRIG_S: begin
          s     <= quad[1] ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});
          state <= S_TRIG_P;
        end
        S_TRIG_P: begin
          // Cosine gives the x end point, sine the y end point.
          if (!trig_phase) begin
            ex         <= end_val;
            trig_phase <= 1'b1;
            state      <= S_TRIG_Z;
          end else begin
            ey     <= end_val;
            target <= 2'd2;
            state  <= S_CONV_START;
          end
        end
        S_LINE_SETUP: begin
          dx    <= (x1 > x0) ? x1 - x0 : x0 - x1;
          dy    <= (y1 > y0) ? y1 - y0 : y0 - y1;
          sx    <= (x0 < x1);
          sy    <= (y0 < y1);
          err   <= ES'((x1 > x0) ? x1 - x0 : x0 - x1) - ES'((y1 > y0) ? y1 - y0 : y0 - y1);
          cx    <= x0;
          cy    <= y0;
          state <= S_LINE_CHECK;
        end
        S_LINE_CHECK: begin
          state <= (cx == x1 && cy == y1) ? S_MARK : S_LINE_RMW;
        end
        S_LINE_RMW: begin
          if (ram_rdata == CELL_UNKNOWN && freed != '1) begin
            freed <= freed + FREED_W'(1);
          end
          err <= err - (step_x ? ES'(dy) : ES'(0)) + (step_y ? ES'(dx) : ES'(0));
          if (step_x) begin
            cx <= sx ? cx + CW'(1) : cx - CW'(1);
          end
          if (step_y) begin
            cy <= sy ? cy + CW'(1) : cy - CW'(1);
          end
          state <= S_LINE_CHECK;
        end
        S_MARK: begin
          res_status <= clamped ? ST_MAX_RANGE : ST_HIT;
          state      <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            out_status    <= res_status;
            out_value     <= res_value;
            out_freed     <= freed;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: design/ogru_checker.sv
// Port-level checks of the occupancy grid ray update block, bound to the top level.
module ogru_checker
  import ogru_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [STATUS_W-1:0]   m_axis_tuser
);

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                        && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // Taking a request moves the sequencer out of idle.
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken on consecutive cycles");

  // Only a cell read carries a cell value.
  a_value_only_read: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != ST_CELL_READ |-> m_axis_tdata[VALUE_W-1:0] == '0)
    else $error("cell value on a result that is not a read");

  // Only a traced line frees cells.
  a_freed_only_traced: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != ST_HIT && m_axis_tuser != ST_MAX_RANGE
      |-> m_axis_tdata[VALUE_W +: FREED_W] == '0)
    else $error("freed count on a result without a traced line");

endmodule

bind occupancy_grid_ray_update ogru_checker u_ogru_checker (.*);

FILE: sim/testbench.sv
// Self-checking testbench for the occupancy grid ray update block.
`timescale 1ns / 100ps

module testbench;
  import ogru_pkg::*;

  localparam logic [CMD_W-1:0] CMD_READ = 2'd2;
  localparam int GRID_CELLS = OGRU_GRID_WIDTH * OGRU_GRID_HEIGHT;

  // One beam, clear or read request as the sender builds it.
  typedef struct {
    logic [CMD_W-1:0]   cmd;
    logic [POS_W-1:0]   rx;
    logic [POS_W-1:0]   ry;
    logic [ANG_W-1:0]   head;
    logic [RANGE_W-1:0] range;
    logic [BEAM_W-1:0]  beam;
    logic [SEL_W-1:0]   cx;
    logic [SEL_W-1:0]   cy;
  } beam_req_t;

  // What the block should answer for one request.
  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  value;
    logic [FREED_W-1:0]  freed;
  } grid_outcome_t;

  // The scoreboard keeps its own copy of the grid and the registers and predicts every
  // outcome at the moment its request is accepted; results come back in request order.
  class ray_scoreboard;
    logic [VALUE_W-1:0]     cells [GRID_CELLS];
    logic [POS_W-1:0]       org_x, org_y;
    logic [CELL_SIZE_W-1:0] csz;
    logic [ANG_W-1:0]       ang0, astep;
    logic [RANGE_W-1:0]     rmin, rmax;
    grid_outcome_t          pending[$];
    int                     errors;
    int                     last_x, last_y;

    function new();
      foreach (cells[i]) cells[i] = CELL_UNKNOWN;
      org_x = '0;
      org_y = '0;
      csz   = 10'd50;
      ang0  = '0;
      astep = '0;
      rmin  = '0;
      rmax  = 16'hFFFF;
      errors = 0;
      last_x = 0;
      last_y = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        CFG_ORIGIN_X:  org_x = v;
        CFG_ORIGIN_Y:  org_y = v;
        CFG_CELL_SIZE: csz   = v[CELL_SIZE_W-1:0];
        CFG_FIRST_ANG: ang0  = v[ANG_W-1:0];
        CFG_ANG_STEP:  astep = v[ANG_W-1:0];
        CFG_MIN_RANGE: rmin  = v[RANGE_W-1:0];
        CFG_MAX_RANGE: rmax  = v[RANGE_W-1:0];
        default: ;
      endcase
    endfunction

    // Polynomial sine in Q1.15 over a binary angle.
    function longint q15_sin(logic [ANG_W-1:0] a);
      longint z, z2, t, s;
      z = a[13:0];
      if (a[14]) z = QUARTER - z;
      z2 = (z * z) >> 14;
      t = SIN_C0 - ((SIN_C1 * z2) >> 14);
      t = SIN_C2 - ((t * z2) >> 14);
      s = (z * t) >> 13;
      if (s > SIN_MAX) s = SIN_MAX;
      return a[15] ? -s : s;
    endfunction

    // Floor division of a world coordinate into a cell index below lim; zero size counts
    // as one.
    function bit to_cell(longint w, logic [POS_W-1:0] org, longint lim, output int c);
      longint o, cs, q;
      o = $signed(org);
      cs = (csz == 0) ? 1 : csz;
      c = 0;
      if (w < o) return 0;
      q = (w - o) / cs;
      if (q >= lim) return 0;
      c = int'(q);
      return 1;
    endfunction

    function void note_request(beam_req_t q);
      grid_outcome_t o;
      longint rx, ry, rng, ex, ey;
      int x0, y0, x1, y1, dx, dy, sx, sy, err, e2, px, py, freed;
      bit clamped;
      logic [ANG_W-1:0] ang;
      o.status = ST_CELL_READ;
      o.value = CELL_UNKNOWN;
      freed = 0;
      clamped = 0;
      if (q.cmd == CMD_CLEAR) begin
        foreach (cells[i]) cells[i] = CELL_UNKNOWN;
        o.status = ST_CLEARED;
      end else if (q.cmd == CMD_CAST) begin
        rx = $signed(q.rx);
        ry = $signed(q.ry);
        rng = q.range;
        if (!to_cell(rx, org_x, OGRU_GRID_WIDTH, x0) ||
            !to_cell(ry, org_y, OGRU_GRID_HEIGHT, y0)) begin
          o.status = ST_ROBOT_OUT;
        end else if (rng <= rmax && rng < rmin) begin
          o.status = ST_SHORT;
        end else begin
          if (rng > rmax) begin
            rng = rmax;
            clamped = 1;
          end
          ang = q.head + ang0 + q.beam * astep;
          ex = rx + ((rng * q15_sin(ang + 16'(QUARTER))) >>> 15);
          ey = ry + ((rng * q15_sin(ang)) >>> 15);
          if (!to_cell(ex, org_x, OGRU_GRID_WIDTH, x1) ||
              !to_cell(ey, org_y, OGRU_GRID_HEIGHT, y1)) begin
            o.status = ST_END_OUT;
          end else begin
            // Walk the line from the robot cell, stopping short of the end cell.
            dx = (x1 > x0) ? x1 - x0 : x0 - x1;
            dy = (y1 > y0) ? y1 - y0 : y0 - y1;
            sx = (x0 < x1) ? 1 : -1;
            sy = (y0 < y1) ? 1 : -1;
            err = dx - dy;
            px = x0;
            py = y0;
            while (!(px == x1 && py == y1)) begin
              e2 = 2 * err;
              if (cells[py * OGRU_GRID_WIDTH + px] == CELL_UNKNOWN) begin
                cells[py * OGRU_GRID_WIDTH + px] = CELL_FREE;
                freed++;
              end
              if (e2 > -dy) begin
                err -= dy;
                px += sx;
              end
              if (e2 < dx) begin
                err += dx;
                py += sy;
              end
            end
            if (!clamped) cells[y1 * OGRU_GRID_WIDTH + x1] = CELL_OCCUPIED;
            o.status = clamped ? ST_MAX_RANGE : ST_HIT;
            last_x = x1;
            last_y = y1;
          end
        end
      end else begin
        o.value = cells[q.cy * OGRU_GRID_WIDTH + q.cx];
      end
      if (freed > 511) freed = 511;
      o.freed = freed[FREED_W-1:0];
      pending.push_back(o);
    endfunction

    function void check_result(logic [STATUS_W-1:0] st, logic [OUT_DATA_W-1:0] d);
      grid_outcome_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Result with nothing expected: status %0d data %h", st, d);
        return;
      end
      e = pending.pop_front();
      if (st !== e.status || d[1:0] !== e.value || d[10:2] !== e.freed) begin
        errors++;
        if (errors <= 10)
          $display("Mismatch: expected status %0d value %0d freed %0d, got %0d %0d %0d",
                   e.status, e.value, e.freed, st, d[1:0], d[10:2]);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [CMD_W-1:0]      s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]   m_axis_tuser;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ray_scoreboard sb;
  bit            no_idle;
  int            clears_left;

  occupancy_grid_ray_update u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Safety net: the slowest legal run, with the reset sweep and a handful of full-grid
  // clears, stays well below this bound.
  initial begin
    #60000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result side: every accepted result is checked against the oldest prediction. The
  // ready line drops in random stall bursts until the final phase.
  initial begin : result_side
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
        sb.check_result(m_axis_tuser, m_axis_tdata);
      if (stall_left > 0) begin
        stall_left--;
      end else if (!no_idle && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(1, 17);
      end
      m_axis_tready <= (stall_left == 0);
    end
  end

  // Register write; the caller lowers the write enable after the last one.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    sb.write_reg(idx, v);
  endtask

  task automatic configure(int ox, int oy, int cs, int a0, int step, int rmin, int rmax);
    write_reg(CFG_ORIGIN_X, ox[CFG_DATA_W-1:0]);
    write_reg(CFG_ORIGIN_Y, oy[CFG_DATA_W-1:0]);
    write_reg(CFG_CELL_SIZE, cs[CFG_DATA_W-1:0]);
    write_reg(CFG_FIRST_ANG, a0[CFG_DATA_W-1:0]);
    write_reg(CFG_ANG_STEP, step[CFG_DATA_W-1:0]);
    write_reg(CFG_MIN_RANGE, rmin[CFG_DATA_W-1:0]);
    write_reg(CFG_MAX_RANGE, rmax[CFG_DATA_W-1:0]);
    cfg_write <= 1'b0;
  endtask

  // Holds the sender off until every predicted result has come back. The valid line
  // drops first so that the last request is not taken a second time.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Presents one request and returns once it has been accepted. The valid line stays
  // high so that back-to-back requests need no extra assignment.
  task automatic send_request(beam_req_t q);
    if (!no_idle && $urandom_range(0, 9) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= q.cmd;
    s_axis_tdata  <= {2'd0, q.cy, q.cx, q.beam, q.range, q.head, q.ry, q.rx};
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    sb.note_request(q);
  endtask

  task automatic cast(int rx, int ry, int head, int range, int beam);
    beam_req_t q;
    q.cmd = CMD_CAST;
    q.rx = rx[POS_W-1:0];
    q.ry = ry[POS_W-1:0];
    q.head = head[ANG_W-1:0];
    q.range = range[RANGE_W-1:0];
    q.beam = beam[BEAM_W-1:0];
    q.cx = SEL_W'($urandom);
    q.cy = SEL_W'($urandom);
    send_request(q);
  endtask

  task automatic read_cell(logic [CMD_W-1:0] cmd, int x, int y);
    beam_req_t q;
    q.cmd = cmd;
    q.rx = POS_W'($urandom);
    q.ry = POS_W'($urandom);
    q.head = ANG_W'($urandom);
    q.range = RANGE_W'($urandom);
    q.beam = BEAM_W'($urandom);
    q.cx = x[SEL_W-1:0];
    q.cy = y[SEL_W-1:0];
    send_request(q);
  endtask

  // World coordinate that mostly lands inside the grid under the current registers.
  function automatic logic [POS_W-1:0] grid_pos(logic [POS_W-1:0] org);
    longint v;
    longint eff;
    eff = (sb.csz == 0) ? 1 : sb.csz;
    if ($urandom_range(0, 19) == 0) return POS_W'($urandom);
    v = longint'($signed(org)) + longint'($urandom_range(0, int'(256 * eff - 1)));
    if ($urandom_range(0, 19) == 0) v = longint'($signed(org)) - 1;
    return v[POS_W-1:0];
  endfunction

  task automatic random_request();
    beam_req_t q;
    int pick, cap;
    pick = $urandom_range(0, 99);
    q.cmd = CMD_W'($urandom);
    q.rx = POS_W'($urandom);
    q.ry = POS_W'($urandom);
    q.head = ANG_W'($urandom);
    q.range = RANGE_W'($urandom);
    q.beam = BEAM_W'($urandom);
    q.cx = SEL_W'($urandom);
    q.cy = SEL_W'($urandom);
    if (pick >= 10 && pick < 25) begin
      // Reads, just over half of them aimed at or beside the cell the last beam ended in.
      q.cmd = ($urandom_range(0, 7) == 0) ? 2'd3 : CMD_READ;
      if (pick < 18) begin
        q.cx = SEL_W'(sb.last_x + $urandom_range(0, 2) - 1);
        q.cy = SEL_W'(sb.last_y + $urandom_range(0, 2) - 1);
      end
    end else if (pick >= 25) begin
      q.cmd = CMD_CAST;
      q.rx = grid_pos(sb.org_x);
      q.ry = grid_pos(sb.org_y);
      cap = ((sb.csz == 0) ? 1 : sb.csz) * 130;
      if (cap > 65535) cap = 65535;
      if ($urandom_range(0, 9) != 0) q.range = RANGE_W'($urandom_range(0, cap));
      if ($urandom_range(0, 3) != 0) q.beam = BEAM_W'($urandom_range(0, 400));
    end
    // A clear sweeps the whole grid, so only a few are let through.
    if (q.cmd == CMD_CLEAR) begin
      if (clears_left == 0) q.cmd = CMD_READ;
      else clears_left--;
    end
    send_request(q);
  endtask

  initial begin : stimulus
    int ph;
    sb = new();
    no_idle = 0;
    clears_left = 3;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part under the reset settings: the grid spans 0 to 12800 mm on both axes.
    configure(0, 0, 50, 0, 0, 0, 65535);
    s_axis_tvalid <= 1'b0;
    read_cell(CMD_READ, 0, 0);
    read_cell(2'd3, 255, 255);
    cast(6400, 6400, 0, 3000, 0);
    read_cell(CMD_READ, 188, 128);
    read_cell(CMD_READ, 129, 128);
    cast(6400, 6400, 16384, 65535, 0);
    cast(6400, 6400, 32768, 0, 0);
    cast(6400, 6400, 49152, 6400, 0);
    read_cell(CMD_READ, 128, 0);
    cast(6400, 6400, 65535, 1000, 4095);
    cast(6400, 6400, 8192, 5000, 7);
    cast(-1, 6400, 0, 1000, 0);
    cast(12800, 6400, 0, 1000, 0);
    cast(1048575, -1048576, 0, 1000, 0);
    cast(12799, 12799, 0, 0, 0);
    read_cell(CMD_READ, 255, 255);
    read_cell(CMD_CLEAR, 0, 0);
    read_cell(CMD_READ, 188, 128);

    // Random phases, each under its own register setting; the sender pauses until the
    // block has drained before every change.
    for (ph = 0; ph < 6; ph++) begin
      wait_drained();
      case (ph)
        0: configure(0, 0, 50, 0, 0, 0, 65535);
        1: configure(-1000000, -1000000, 20, $urandom_range(0, 65535),
                     $urandom_range(0, 65535), 100, 3000);
        2: configure(1000000, -1000000, 1000, 65535, 65535, 0, 0);
        3: configure($urandom_range(0, 2000000) - 1000000, -5000, 0, 0, 1, 10, 200);
        4: configure(-20000, 300000, $urandom_range(1, 1000), $urandom_range(0, 65535),
                     $urandom_range(0, 65535), 65535, 65535);
        default: configure(0, -100, 1, $urandom_range(0, 65535), $urandom_range(0, 65535),
                           0, 1000);
      endcase
      if (ph == 5) no_idle = 1;
      repeat ((ph == 4) ? 50 : 160) random_request();
    end

    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (40) @(posedge clk);
    if (sb.pending.size() != 0) sb.errors++;
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: files.f
design/ogru_pkg.sv
design/ogru_ram.sv
design/occupancy_grid_ray_update.sv
design/ogru_checker.sv
sim/testbench.sv
